// File: hw/rtl/pckf_pkg.sv
// Shared constants and opcodes for the particle color keyframe interpolator.
// No dependencies; used by pckf_locate and the top level.
package pckf_pkg;

  localparam int TIME_BITS = 20;
  localparam int MAX_KEYS  = 16;
  localparam int KEY_W     = $clog2(MAX_KEYS);
  localparam int CNT_W     = $clog2(MAX_KEYS + 1);
  localparam int RATIO_W   = 16;

  // remainder of seg*life / n is taken this many bits per stage
  localparam int MOD_STEP   = 3;
  localparam int PROD_W     = KEY_W + TIME_BITS;
  localparam int MOD_STAGES = (PROD_W + MOD_STEP - 1) / MOD_STEP;

  // input reg, segment divide, product, remainder, add, ratio divide
  localparam int LOC_LAT = 1 + KEY_W + 1 + MOD_STAGES + 1 + RATIO_W;

  localparam int CFG_W     = TIME_BITS;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_LIFETIME  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VIS_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 2'd2;

  localparam logic [TIME_BITS-1:0] LIFETIME_RESET = TIME_BITS'(1000);

  localparam logic [1:0] OP_EVAL      = 2'd0;
  localparam logic [1:0] OP_WRITE_COL = 2'd1;
  localparam logic [1:0] OP_WRITE_VIS = 2'd2;

  localparam int VIS_W       = 9;
  localparam int COLOR_W     = 32;
  localparam int S_TDATA_W   = 64;
  localparam int M_TDATA_W   = 40;

endpackage

// File: hw/rtl/pckf_locate.sv
// Segment and Q0.16 ratio finder for equally spaced keys over the lifetime.
// Pipelined restoring dividers; depends on pckf_pkg.
module pckf_locate (
  input  logic                             clk,
  input  logic                             en,
  input  logic [pckf_pkg::TIME_BITS-1:0]   t,
  input  logic [pckf_pkg::TIME_BITS-1:0]   life,
  input  logic [pckf_pkg::CNT_W-1:0]       n,
  input  logic [pckf_pkg::KEY_W-1:0]       last,
  output logic [pckf_pkg::KEY_W-1:0]       seg,
  output logic [pckf_pkg::RATIO_W-1:0]     ratio,
  output logic                             at_last
);

  localparam int TB = pckf_pkg::TIME_BITS;
  localparam int NW = pckf_pkg::CNT_W;
  localparam int AW = pckf_pkg::KEY_W;
  localparam int DW = TB + NW;
  localparam int PW = pckf_pkg::PROD_W;
  localparam int MS = pckf_pkg::MOD_STAGES;
  localparam int MSTEP = pckf_pkg::MOD_STEP;
  localparam int RB = pckf_pkg::RATIO_W;

  // seg = n*t / life, one quotient bit per stage
  logic [DW-1:0] drem [0:AW];
  logic [AW-1:0] dquo [0:AW];
  logic          dovf [0:AW];

  always_ff @(posedge clk) begin
    if (en) begin
      drem[0] <= DW'(n) * DW'(t);
      dquo[0] <= '0;
      dovf[0] <= 1'b0;
      for (int j = 0; j < AW; j++) begin
        if (j == 0) begin
          dovf[j+1] <= drem[0] >= (DW'(life) << AW);
        end else begin
          dovf[j+1] <= dovf[j];
        end
        if (drem[j] >= (DW'(life) << (AW - 1 - j))) begin
          drem[j+1] <= drem[j] - (DW'(life) << (AW - 1 - j));
          dquo[j+1] <= {dquo[j][AW-2:0], 1'b1};
        end else begin
          drem[j+1] <= drem[j];
          dquo[j+1] <= {dquo[j][AW-2:0], 1'b0};
        end
      end
    end
  end

  // (seg*life) mod n, bit serial over MS stages
  logic [NW-1:0] mrem  [0:MS];
  logic [PW-1:0] mprod [0:MS];
  logic [TB-1:0] mrem1 [0:MS];
  logic [AW-1:0] mseg  [0:MS];
  logic          mlast [0:MS];
  logic [NW-1:0] mnext [0:MS-1];

  always_comb begin
    logic [NW-1:0] acc;
    acc = '0;
    for (int j = 0; j < MS; j++) begin
      acc = mrem[j];
      for (int s = 0; s < MSTEP; s++) begin
        if (PW - 1 - (MSTEP * j + s) >= 0) begin
          acc = {acc[NW-2:0], mprod[j][PW-1-(MSTEP*j+s)]};
          if (acc >= n) begin
            acc = acc - n;
          end
        end
      end
      mnext[j] = acc;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mrem[0]  <= '0;
      mprod[0] <= PW'(dquo[AW]) * PW'(life);
      mrem1[0] <= drem[AW][TB-1:0];
      mseg[0]  <= dquo[AW];
      mlast[0] <= dovf[AW] || (dquo[AW] >= last);
      for (int j = 0; j < MS; j++) begin
        mrem[j+1]  <= mnext[j];
        mprod[j+1] <= mprod[j];
        mrem1[j+1] <= mrem1[j];
        mseg[j+1]  <= mseg[j];
        mlast[j+1] <= mlast[j];
      end
    end
  end

  // rel*n = rem1 + mod; ratio = rel*n*65536 / life
  logic [TB:0]   rrem  [0:RB];
  logic [RB-1:0] rquo  [0:RB];
  logic          rsat  [0:RB];
  logic [AW-1:0] rseg  [0:RB];
  logic          rlast [0:RB];

  always_ff @(posedge clk) begin
    if (en) begin
      rrem[0]  <= (TB+1)'(mrem1[MS]) + (TB+1)'(mrem[MS]);
      rquo[0]  <= '0;
      rsat[0]  <= 1'b0;
      rseg[0]  <= mseg[MS];
      rlast[0] <= mlast[MS];
      for (int j = 0; j < RB; j++) begin
        if ({rrem[j], 1'b0} >= (TB+2)'(life)) begin
          rrem[j+1] <= (TB+1)'({rrem[j], 1'b0} - (TB+2)'(life));
          rquo[j+1] <= {rquo[j][RB-2:0], 1'b1};
        end else begin
          rrem[j+1] <= (TB+1)'({rrem[j], 1'b0});
          rquo[j+1] <= {rquo[j][RB-2:0], 1'b0};
        end
        if (j == 0) begin
          rsat[j+1] <= rrem[0] >= (TB+1)'(life);
        end else begin
          rsat[j+1] <= rsat[j];
        end
        rseg[j+1]  <= rseg[j];
        rlast[j+1] <= rlast[j];
      end
    end
  end

  assign seg     = rseg[RB];
  assign ratio   = rsat[RB] ? '1 : rquo[RB];
  assign at_last = rlast[RB];

endmodule

// File: hw/rtl/particle_color_keyframe_interp_top.sv
// Particle color keyframe interpolator, top level.
// Depends on pckf_pkg and pckf_locate (two lanes: color and visibility).
//
// Channel   Dir  Signals                     Beat contents
// s_*       in   s_tvalid/s_tready/s_tdata   opcode, key_index, key_value, elapsed_ms
// m_*       out  m_tvalid/m_tready/m_tdata   color_argb, expired
// cfg_*     in   cfg_we/cfg_index/cfg_data   lifetime_ms, vis_key_count, color_key_count
//
// One beat enters per cycle while the output is not stalled: the segment
// and ratio dividers in pckf_locate make up most of the pipe, then key read, lerp, scale.
// Key writes travel the pipe and land in the key tables at the read stage,
// so tables always match beat order.
// A stalled output freezes the whole pipe (s_tready = !m_tvalid | m_tready).
// rst is synchronous and clears valid bits and config registers only.
module particle_color_keyframe_interp_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // [1:0] opcode, [5:2] key_index, [37:6] key_value, [57:38] elapsed_ms
  input  logic [pckf_pkg::S_TDATA_W-1:0]     s_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // [31:0] color_argb, [32] expired
  output logic [pckf_pkg::M_TDATA_W-1:0]     m_tdata,
  input  logic                               cfg_we,
  input  logic [pckf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pckf_pkg::CFG_W-1:0]         cfg_data
);

  localparam int TB  = pckf_pkg::TIME_BITS;
  localparam int NW  = pckf_pkg::CNT_W;
  localparam int AW  = pckf_pkg::KEY_W;
  localparam int RB  = pckf_pkg::RATIO_W;
  localparam int VW  = pckf_pkg::VIS_W;
  localparam int CW  = pckf_pkg::COLOR_W;
  localparam int LAT = pckf_pkg::LOC_LAT;

  typedef struct packed {
    logic          eval;
    logic          wcol;
    logic          wvis;
    logic          expired;
    logic [AW-1:0] idx;
    logic [CW-1:0] val;
  } side_t;

  // input fields
  logic [1:0]    in_op;
  logic [AW-1:0] in_idx;
  logic [CW-1:0] in_val;
  logic [TB-1:0] in_t;
  assign in_op  = s_tdata[1:0];
  assign in_idx = s_tdata[2 +: AW];
  assign in_val = s_tdata[2 + AW +: CW];
  assign in_t   = s_tdata[2 + AW + CW +: TB];

  // configuration
  logic [TB-1:0] lifetime;
  logic [NW-1:0] vis_cnt;
  logic [NW-1:0] col_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      lifetime <= pckf_pkg::LIFETIME_RESET;
      vis_cnt  <= NW'(1);
      col_cnt  <= NW'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        pckf_pkg::REG_LIFETIME:  lifetime <= cfg_data[TB-1:0];
        pckf_pkg::REG_VIS_COUNT: vis_cnt  <= cfg_data[NW-1:0];
        pckf_pkg::REG_COL_COUNT: col_cnt  <= cfg_data[NW-1:0];
        default: ;
      endcase
    end
  end

  // zero lifetime acts as one; counts clamp to 1..MAX_KEYS
  logic [TB-1:0] life;
  logic [NW-1:0] vcl;
  logic [NW-1:0] ccl;
  assign life = (lifetime == '0) ? TB'(1) : lifetime;
  assign vcl  = (vis_cnt == '0) ? NW'(1) :
                (vis_cnt > NW'(pckf_pkg::MAX_KEYS)) ? NW'(pckf_pkg::MAX_KEYS) : vis_cnt;
  assign ccl  = (col_cnt == '0) ? NW'(1) :
                (col_cnt > NW'(pckf_pkg::MAX_KEYS)) ? NW'(pckf_pkg::MAX_KEYS) : col_cnt;

  logic [AW-1:0] vlast_idx;
  logic [AW-1:0] clast_idx;
  assign vlast_idx = AW'(vcl - NW'(1));
  assign clast_idx = AW'(ccl - NW'(1));

  // whole pipe advances unless the output beat is stuck
  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // locate lanes: color keys sit at i*L/(c-1), visibility keys at i*L/c
  logic [AW-1:0] c_seg, v_seg;
  logic [RB-1:0] c_ratio, v_ratio;
  logic          c_last, v_last;

  pckf_locate u_col_loc (
    .clk     (clk),
    .en      (en),
    .t       (in_t),
    .life    (life),
    .n       (ccl - NW'(1)),
    .last    (clast_idx),
    .seg     (c_seg),
    .ratio   (c_ratio),
    .at_last (c_last)
  );

  pckf_locate u_vis_loc (
    .clk     (clk),
    .en      (en),
    .t       (in_t),
    .life    (life),
    .n       (vcl),
    .last    (vlast_idx),
    .seg     (v_seg),
    .ratio   (v_ratio),
    .at_last (v_last)
  );

  // side data delay line, aligned with the locate outputs
  logic  sb_v [0:LAT-1];
  side_t sb   [0:LAT-1];
  side_t sb_in;

  always_comb begin
    sb_in.eval    = (in_op == pckf_pkg::OP_EVAL);
    sb_in.wcol    = (in_op == pckf_pkg::OP_WRITE_COL);
    sb_in.wvis    = (in_op == pckf_pkg::OP_WRITE_VIS);
    sb_in.expired = in_t > life;
    sb_in.idx     = in_idx;
    sb_in.val     = in_val;
  end

  // read stage, lerp stage, scale (output) stage
  logic          r_v, l_v, o_v;
  logic          r_exp, l_exp;
  logic          r_clast, r_vlast;
  logic [RB-1:0] r_cratio, r_vratio;
  logic [CW-1:0] cka, ckb;
  logic [VW-1:0] vka, vkb;
  logic [CW-1:0] l_col;
  logic [VW-1:0] l_vis;
  logic [pckf_pkg::M_TDATA_W-1:0] o_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LAT; i++) begin
        sb_v[i] <= 1'b0;
      end
      r_v <= 1'b0;
      l_v <= 1'b0;
      o_v <= 1'b0;
    end else if (en) begin
      sb_v[0] <= s_tvalid;
      for (int i = 1; i < LAT; i++) begin
        sb_v[i] <= sb_v[i-1];
      end
      r_v <= sb_v[LAT-1] && sb[LAT-1].eval;
      l_v <= r_v;
      o_v <= l_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb[0] <= sb_in;
      for (int i = 1; i < LAT; i++) begin
        sb[i] <= sb[i-1];
      end
    end
  end

  // key tables: written and read at the same stage
  logic [CW-1:0] col_mem [0:pckf_pkg::MAX_KEYS-1];
  logic [VW-1:0] vis_mem [0:pckf_pkg::MAX_KEYS-1];

  always_ff @(posedge clk) begin
    if (en) begin
      if (sb_v[LAT-1] && sb[LAT-1].wcol) begin
        col_mem[sb[LAT-1].idx] <= sb[LAT-1].val;
      end
      if (sb_v[LAT-1] && sb[LAT-1].wvis) begin
        vis_mem[sb[LAT-1].idx] <= sb[LAT-1].val[VW-1:0];
      end
      cka <= col_mem[c_last ? clast_idx : c_seg];
      ckb <= col_mem[c_seg + AW'(1)];
      vka <= vis_mem[v_last ? vlast_idx : v_seg];
      vkb <= vis_mem[v_seg + AW'(1)];
      r_exp    <= sb[LAT-1].expired;
      r_clast  <= c_last;
      r_vlast  <= v_last;
      r_cratio <= c_ratio;
      r_vratio <= v_ratio;
    end
  end

  // (ka*(65536-r) + kb*r) >> 16
  function automatic logic [VW+1:0] lerp(input logic [VW-1:0] ka,
                                          input logic [VW-1:0] kb,
                                          input logic [RB-1:0] r);
    logic [VW+RB+1:0] acc;
    acc = (VW+RB+2)'(ka) * (VW+RB+2)'((RB+1)'(1) << RB) - (VW+RB+2)'(ka) * (VW+RB+2)'(r)
        + (VW+RB+2)'(kb) * (VW+RB+2)'(r);
    return acc[RB +: VW+2];
  endfunction

  logic [CW-1:0] col_lerp;
  logic [VW-1:0] vis_lerp;

  always_comb begin
    logic [VW+1:0] ch;
    logic [VW+1:0] vv;
    for (int k = 0; k < 4; k++) begin
      ch = lerp(VW'(cka[8*k +: 8]), VW'(ckb[8*k +: 8]), r_cratio);
      col_lerp[8*k +: 8] = (ch > (VW+2)'(255)) ? 8'hFF : ch[7:0];
    end
    vv = lerp(vka, vkb, r_vratio);
    vis_lerp = vv[VW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      l_col <= r_clast ? cka : col_lerp;
      l_vis <= r_vlast ? vka : vis_lerp;
      l_exp <= r_exp;
    end
  end

  // scale each channel by visibility (Q1.8), saturating
  logic [CW-1:0] scaled;

  always_comb begin
    logic [VW+7:0] p;
    for (int k = 0; k < 4; k++) begin
      p = (VW+8)'(l_col[8*k +: 8]) * (VW+8)'(l_vis);
      scaled[8*k +: 8] = (p[VW+7:8] > VW'(255)) ? 8'hFF : p[15:8];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_data <= {(pckf_pkg::M_TDATA_W - CW - 1)'(0), l_exp, scaled};
    end
  end

  assign m_tvalid = o_v;
  assign m_tdata  = o_data;

endmodule

// File: hw/rtl/pckf_checker.sv
// Port-level checks for particle_color_keyframe_interp_top, with bind.
// Depends on pckf_pkg for widths.
module pckf_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [pckf_pkg::M_TDATA_W-1:0] m_tdata
);

  // no result survives reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // input side is held only while the output beat is stuck
  a_ready_follows_out: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("s_tready does not track output stall");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // pad bits above expired stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[pckf_pkg::M_TDATA_W-1:pckf_pkg::COLOR_W+1] == '0)
    else $error("nonzero pad in result");

  // no result rises straight out of reset
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(rst))
    else $error("result appeared straight out of reset");

endmodule

bind particle_color_keyframe_interp_top pckf_checker u_pckf_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// File: dv/tb_particle_color_keyframe_interp_top.sv
// Self-checking bench for the particle color keyframe interpolator top level.
// Needs pckf_pkg and the RTL; predicts every evaluate beat and checks color and expired in order.
`timescale 1ns / 1ps

module tb_particle_color_keyframe_interp_top;

  localparam int SW = pckf_pkg::S_TDATA_W;
  localparam int MW = pckf_pkg::M_TDATA_W;
  localparam int NK = pckf_pkg::MAX_KEYS;
  localparam logic [1:0] OP_UNUSED  = 2'd3;
  localparam logic [pckf_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  // packed from the lowest bit up: opcode, key_index, key_value, elapsed_ms
  typedef struct packed {
    logic [19:0] elapsed_ms;
    logic [31:0] key_value;
    logic [3:0]  key_index;
    logic [1:0]  opcode;
  } beat_t;

  // packed from the lowest bit up: color_argb, expired
  typedef struct packed {
    logic        expired;
    logic [31:0] color_argb;
  } shade_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [SW-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [MW-1:0] m_tdata;
  logic cfg_we = 1'b0;
  logic [pckf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [pckf_pkg::CFG_W-1:0] cfg_data = '0;

  particle_color_keyframe_interp_top DUT (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state: key tables plus the three settings
  logic [31:0] col_tab [NK];
  logic [8:0]  vis_tab [NK];
  logic [19:0] life_reg = pckf_pkg::LIFETIME_RESET;
  logic [4:0]  vis_cnt = 5'd1;
  logic [4:0]  col_cnt = 5'd1;

  beat_t  pending_beats[$];
  shade_t shade_queue[$];
  int     mismatches = 0;
  int     cycles = 0;
  bit     quiet = 0;      // no idling in the last part of the run
  bit     hold_src = 0;   // sender hold-off until drained
  localparam int LIMIT = 400000;

  function automatic void add_beat(beat_t b);
    pending_beats.insert(pending_beats.size(), b);
  endfunction

  function automatic int eff_count(logic [4:0] c);
    if (c == 0) return 1;
    if (c > NK) return NK;
    return c;
  endfunction

  // segment/ratio search over keys spaced at i*L/n; 0 means at or past the last key
  function automatic bit find_seg(longint t, longint life, longint n, longint last,
                                  output longint seg, output longint ratio);
    longint a, st, r;
    a = (n * t) / life;
    seg = 0;
    ratio = 0;
    if (a >= last) return 0;
    st = (a * life) / n;
    r = ((t - st) * n * 65536) / life;
    if (r > 65535) r = 65535;
    seg = a;
    ratio = r;
    return 1;
  endfunction

  function automatic longint blend(longint ka, longint kb, longint r);
    return (ka * (65536 - r) + kb * r) >>> 16;
  endfunction

  function automatic shade_t shade_of(logic [19:0] age);
    longint life, t, c, seg, r, v, vis;
    logic [31:0] col, ka, kb;
    shade_t s;
    life = (life_reg == 0) ? 1 : life_reg;
    t = age;
    c = eff_count(col_cnt);
    if (c < 2 || !find_seg(t, life, c - 1, c - 1, seg, r)) col = col_tab[c-1];
    else begin
      ka = col_tab[seg];
      kb = col_tab[seg+1];
      for (int sh = 0; sh < 32; sh += 8) begin
        v = blend((ka >> sh) & 8'hFF, (kb >> sh) & 8'hFF, r);
        if (v > 255) v = 255;
        col[sh +: 8] = v[7:0];
      end
    end
    c = eff_count(vis_cnt);
    if (!find_seg(t, life, c, c - 1, seg, r)) vis = vis_tab[c-1];
    else vis = blend(vis_tab[seg], vis_tab[seg+1], r) & 9'h1FF;
    for (int sh = 0; sh < 32; sh += 8) begin
      v = (longint'(col[sh +: 8]) * vis) >>> 8;
      if (v > 255) v = 255;
      s.color_argb[sh +: 8] = v[7:0];
    end
    s.expired = (t > life);
    return s;
  endfunction

  // track tables at acceptance; evaluates queue their expected shade
  function automatic void accept_beat(beat_t b);
    case (b.opcode)
      pckf_pkg::OP_WRITE_COL: col_tab[b.key_index] = b.key_value;
      pckf_pkg::OP_WRITE_VIS: vis_tab[b.key_index] = b.key_value[8:0];
      pckf_pkg::OP_EVAL:      shade_queue.insert(shade_queue.size(), shade_of(b.elapsed_ms));
      default: ;
    endcase
  endfunction

  // driver
  int src_gap = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst) begin
      if (s_tvalid && s_tready) accept_beat(beat_t'(s_tdata[57:0]));
      if (!s_tvalid || s_tready) begin
        if (src_gap > 0) begin
          src_gap <= src_gap - 1;
          s_tvalid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 15) == 0) begin
          src_gap <= $urandom_range(1, 19);
          s_tvalid <= 1'b0;
        end else if (!hold_src && pending_beats.size() > 0) begin
          s_tdata <= SW'(pending_beats.pop_front());
          s_tvalid <= 1'b1;
        end else s_tvalid <= 1'b0;
      end
    end
  end

  // monitor plus output stall generator
  int sink_gap = 0;
  always @(posedge clk) begin
    shade_t got, want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = shade_t'(m_tdata[32:0]);
        if (shade_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat %h", got);
        end else begin
          want = shade_queue.pop_front();
          if (got.color_argb !== want.color_argb || got.expired !== want.expired) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: argb exp %h got %h, expired exp %b got %b",
                       want.color_argb, got.color_argb, want.expired, got.expired);
          end
        end
      end
      if (sink_gap > 0) begin
        sink_gap <= sink_gap - 1;
        m_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 15) == 0) begin
        sink_gap <= $urandom_range(1, 19);
        m_tready <= 1'b0;
      end else m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (cycles > LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic beat_t mk(logic [1:0] op, logic [3:0] idx, logic [31:0] val,
                               logic [19:0] age);
    beat_t b;
    b.opcode = op;
    b.key_index = idx;
    b.key_value = val;
    b.elapsed_ms = age;
    return b;
  endfunction

  task automatic load_all_keys();
    for (int i = 0; i < NK; i++) begin
      add_beat(mk(pckf_pkg::OP_WRITE_COL, 4'(i), $urandom(), 20'($urandom())));
      add_beat(mk(pckf_pkg::OP_WRITE_VIS, 4'(i), $urandom(), 20'($urandom())));
    end
  endtask

  // wait for drain and let the pipe settle before touching config
  task automatic drain();
    while (pending_beats.size() > 0 || s_tvalid || shade_queue.size() > 0)
      @(posedge clk);
    repeat (pckf_pkg::LOC_LAT + 10) @(posedge clk);
  endtask

  task automatic set_reg(logic [pckf_pkg::CFG_IDX_W-1:0] idx,
                         logic [pckf_pkg::CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      pckf_pkg::REG_LIFETIME:  life_reg = val;
      pckf_pkg::REG_VIS_COUNT: vis_cnt = val[4:0];
      pckf_pkg::REG_COL_COUNT: col_cnt = val[4:0];
      default: ;
    endcase
  endtask

  task automatic random_burst(int n, logic [19:0] life);
    logic [19:0] t;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0: add_beat(mk(pckf_pkg::OP_WRITE_COL, 4'($urandom()), $urandom(),
                       20'($urandom())));
        1: add_beat(mk(pckf_pkg::OP_WRITE_VIS, 4'($urandom()), $urandom(),
                       20'($urandom())));
        2: add_beat(mk(OP_UNUSED, 4'($urandom()), $urandom(), 20'($urandom())));
        3: add_beat(mk(pckf_pkg::OP_EVAL, 4'($urandom()), $urandom(), 20'($urandom())));
        default: begin
          // mostly within lifetime, with edges around it
          t = ($urandom_range(0, 7) == 0) ? 20'(life + $urandom_range(0, 2))
                                          : 20'($urandom_range(0, life));
          add_beat(mk(pckf_pkg::OP_EVAL, 4'($urandom()), $urandom(), t));
        end
      endcase
    end
  endtask

  initial begin
    int lifes [6];
    logic [19:0] life;
    lifes = '{1000, 1, 1048575, 0, 37, 65000};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: full tables, extremes of keys and ages
    add_beat(mk(pckf_pkg::OP_WRITE_COL, 4'd0, 32'hFFFF_FFFF, 20'd0));
    add_beat(mk(pckf_pkg::OP_WRITE_VIS, 4'd0, 32'hFFFF_FFFF, 20'd0));
    add_beat(mk(pckf_pkg::OP_EVAL, 4'd0, 32'd0, 20'd0));
    add_beat(mk(pckf_pkg::OP_EVAL, 4'd0, 32'd0, 20'hFFFFF));
    add_beat(mk(pckf_pkg::OP_EVAL, 4'd0, 32'd0, 20'd1000));
    add_beat(mk(pckf_pkg::OP_EVAL, 4'd0, 32'd0, 20'd1001));
    load_all_keys();
    add_beat(mk(pckf_pkg::OP_WRITE_COL, 4'd15, 32'h0, 20'd0));
    add_beat(mk(pckf_pkg::OP_WRITE_VIS, 4'd15, 32'h100, 20'd0));
    add_beat(mk(OP_UNUSED, 4'd15, 32'hFFFF_FFFF, 20'hFFFFF));
    drain();
    set_reg(pckf_pkg::REG_COL_COUNT, 20'd16);
    set_reg(pckf_pkg::REG_VIS_COUNT, 20'd16);
    set_reg(REG_UNUSED, 20'hFFFFF);
    for (int i = 0; i < 6; i++) add_beat(mk(pckf_pkg::OP_EVAL, 4'd0, 32'd0, 20'(i * 200)));
    drain();

    // random phases across settings, counts 0..31 exercise clamping
    for (int ph = 0; ph < 12; ph++) begin
      life = (ph < 6) ? 20'(lifes[ph]) : 20'($urandom_range(1, 5000));
      set_reg(pckf_pkg::REG_LIFETIME, life);
      set_reg(pckf_pkg::REG_VIS_COUNT,
              20'((ph == 0) ? 0 : (ph == 1) ? 31 : $urandom_range(0, 17)));
      set_reg(pckf_pkg::REG_COL_COUNT,
              20'((ph == 2) ? 0 : (ph == 3) ? 1 : $urandom_range(0, 17)));
      if (ph == 11) quiet = 1;
      random_burst(140, (life == 0) ? 20'd1 : life);
      if (ph == 5) begin
        // sender holds until every result is back
        while (pending_beats.size() > 70) @(posedge clk);
        hold_src = 1;
        while (s_tvalid || shade_queue.size() > 0) @(posedge clk);
        hold_src = 0;
      end
      drain();
    end

    if (mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

// File: files.f
hw/rtl/pckf_pkg.sv
hw/rtl/pckf_locate.sv
hw/rtl/particle_color_keyframe_interp_top.sv
hw/rtl/pckf_checker.sv
dv/tb_particle_color_keyframe_interp_top.sv
